[src/pps_pkg.sv]
// Package for the periodic peer update scheduler: sizes, codes and word types.
`default_nettype none
package pps_pkg;

  localparam int MAX_PEERS = 16;
  localparam int MAX_BURST = 64;
  localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int BURST_W   = 7;

  localparam logic [31:0] SIGN32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_RM   = 2'd1,
    REQ_IVAL = 2'd2,
    REQ_TICK = 2'd3
  } req_code_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOPEERS  = 3'd4;

  localparam logic [1:0] CFG_DEF_IVAL = 2'd0;
  localparam logic [1:0] CFG_BURST    = 2'd1;
  localparam logic [1:0] CFG_IDLE     = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] peer_id;
    logic [15:0] ival_ms;
    logic [15:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic        peer_valid;
    logic [15:0] due_peer;
    logic        last;
    logic [15:0] wait_ms;
    logic [2:0]  status;
  } res_t;

  // Record that walks down the chain of slots, one slot per cycle.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic             best;
    logic [31:0]      best_key;
    logic [15:0]      best_peer;
    logic [15:0]      best_ival;
    logic [IDX_W-1:0] best_idx;
  } scan_t;

  // Slot update broadcast to all cells.
  typedef struct packed {
    logic             add;
    logic             rm;
    logic             ival_en;
    logic             due_en;
    logic [IDX_W-1:0] idx;
    logic [15:0]      peer;
    logic [15:0]      ival;
    logic [31:0]      due;
  } wr_t;

endpackage
`default_nettype wire

[src/periodic_peer_update_scheduler.sv]
// Top level of the periodic peer update scheduler: control, clock and slot chain.
`default_nettype none
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  --------------------------
//  request   start, busy, req                        word taken when start & !busy
//  result    done, res                               word valid for one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  taken when valid & ready
//
//  Every request sweeps the slot chain, one slot per cycle. Add, remove and set
//  interval take two sweeps; a tick takes one sweep per emitted peer plus one.
//  Synchronous reset clears all slots at once; no clearing pass is needed.
//  The receiver cannot stall: results leave on done, one per sweep at most.
//  Configuration is always ready.
module periodic_peer_update_scheduler (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire pps_pkg::req_t req,
  output logic               done,
  output pps_pkg::res_t      res,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import pps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIND  = 4'b0010,
    S_FINAL = 4'b0100,
    S_TICK  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic          launch, launch_next;
  logic [1:0]    op;
  logic [15:0]   id;
  logic [15:0]   ival;
  logic [31:0]   clock_ms;
  logic [2:0]    status, status_next;
  logic [BURST_W-1:0] n_emit, n_emit_next;
  logic          pend, pend_next;
  logic [15:0]   pend_peer, pend_peer_next;
  logic [15:0]   def_ival;
  logic [BURST_W-1:0] burst;
  logic [15:0]   idle_wait;
  logic [BURST_W-1:0] lim;

  scan_t         recs [MAX_PEERS+1];
  scan_t         fin;
  wr_t           wr;
  logic          done_next;
  res_t          res_next;
  logic [31:0]   late;
  logic [31:0]   rem;
  logic [15:0]   wait_val;
  logic          due_now;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      def_ival  <= 16'd50;
      burst     <= BURST_W'(MAX_BURST);
      idle_wait <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEF_IVAL: def_ival  <= cfg_data;
        CFG_BURST:    burst     <= cfg_data[BURST_W-1:0];
        CFG_IDLE:     idle_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the burst limit to 1..MAX_BURST.
  always_comb begin
    if (burst == '0) lim = BURST_W'(1);
    else if (burst > BURST_W'(MAX_BURST)) lim = BURST_W'(MAX_BURST);
    else lim = burst;
  end

  // Inject a fresh scan record at the head of the chain.
  always_comb begin
    recs[0]     = '0;
    recs[0].vld = launch;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_PEERS; g++) begin : g_cell
      pps_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .my_idx  (IDX_W'(g)),
        .clock_ms(clock_ms),
        .id      (id),
        .wr      (wr),
        .rec_in  (recs[g]),
        .rec_out (recs[g+1])
      );
    end
  endgenerate

  assign fin = recs[MAX_PEERS];

  // Wait until the earliest due time, from the finished sweep.
  always_comb begin
    late    = fin.best_key ^ SIGN32;
    rem     = 32'd0 - late;
    due_now = fin.best && !late[31];
    if (!fin.best) wait_val = idle_wait;
    else if (!late[31]) wait_val = 16'd0;
    else if (rem > 32'h0000_FFFF) wait_val = 16'hFFFF;
    else wait_val = rem[15:0];
  end

  always_comb begin
    state_next     = state;
    launch_next    = 1'b0;
    status_next    = status;
    n_emit_next    = n_emit;
    pend_next      = pend;
    pend_peer_next = pend_peer;
    wr             = '0;
    done_next      = 1'b0;
    res_next       = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          launch_next = 1'b1;
          status_next = ST_OK;
          n_emit_next = '0;
          pend_next   = 1'b0;
          state_next  = (req.req_type == REQ_TICK) ? S_TICK : S_FIND;
        end
      end
      S_FIND: begin
        if (fin.vld) begin
          launch_next = 1'b1;
          state_next  = S_FINAL;
          unique case (op)
            REQ_ADD: begin
              if (fin.hit) status_next = ST_DUP;
              else if (!fin.free) status_next = ST_FULL;
              else begin
                wr.add  = 1'b1;
                wr.idx  = fin.free_idx;
                wr.peer = id;
                wr.ival = def_ival;
                wr.due  = clock_ms;
              end
            end
            REQ_RM: begin
              if (!fin.hit) status_next = ST_NOTFOUND;
              else begin
                wr.rm  = 1'b1;
                wr.idx = fin.hit_idx;
              end
            end
            default: begin
              if (!fin.hit) status_next = ST_NOTFOUND;
              else begin
                wr.ival_en = 1'b1;
                wr.idx     = fin.hit_idx;
                wr.ival    = ival;
              end
            end
          endcase
        end
      end
      S_FINAL: begin
        if (fin.vld) begin
          done_next        = 1'b1;
          res_next.last    = 1'b1;
          res_next.wait_ms = wait_val;
          res_next.status  = status;
          state_next       = S_IDLE;
        end
      end
      S_TICK: begin
        if (fin.vld) begin
          if (due_now && n_emit < lim) begin
            // Reschedule the winner and hold it until we know if it ends the burst.
            if (pend) begin
              done_next           = 1'b1;
              res_next.peer_valid = 1'b1;
              res_next.due_peer   = pend_peer;
            end
            wr.due_en      = 1'b1;
            wr.idx         = fin.best_idx;
            wr.due         = clock_ms + {16'd0, fin.best_ival};
            pend_next      = 1'b1;
            pend_peer_next = fin.best_peer;
            n_emit_next    = n_emit + BURST_W'(1);
            launch_next    = 1'b1;
          end else begin
            done_next           = 1'b1;
            res_next.peer_valid = pend;
            res_next.due_peer   = pend ? pend_peer : 16'd0;
            res_next.last       = 1'b1;
            res_next.wait_ms    = wait_val;
            res_next.status     = (!pend && !fin.best) ? ST_NOPEERS : ST_OK;
            state_next          = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launch   <= 1'b0;
      done     <= 1'b0;
      clock_ms <= 32'd0;
      pend     <= 1'b0;
      n_emit   <= '0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      done   <= done_next;
      pend   <= pend_next;
      n_emit <= n_emit_next;
      if (state == S_IDLE && start && req.req_type == REQ_TICK)
        clock_ms <= clock_ms + {16'd0, req.elapsed_ms};
    end
    res       <= res_next;
    status    <= status_next;
    pend_peer <= pend_peer_next;
    if (state == S_IDLE && start) begin
      op   <= req.req_type;
      id   <= req.peer_id;
      ival <= req.ival_ms;
    end
  end

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !res.last |-> busy) else $error("non-final word after request ended");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && res.last |-> !busy) else $error("final word while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted request did not go busy");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    done && !res.peer_valid |-> res.last) else $error("empty word not final");

endmodule
`default_nettype wire

[src/pps_cell.sv]
// One peer slot of the chain: holds the slot and folds it into the passing scan record.
`default_nettype none
module pps_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [pps_pkg::IDX_W-1:0] my_idx,
  input  wire logic [31:0]           clock_ms,
  input  wire logic [15:0]           id,
  input  wire pps_pkg::wr_t          wr,
  input  wire pps_pkg::scan_t        rec_in,
  output pps_pkg::scan_t             rec_out
);
  import pps_pkg::*;

  logic        used;
  logic [15:0] peer;
  logic [15:0] ival;
  logic [31:0] due;
  logic [31:0] key;
  scan_t       rec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (wr.idx == my_idx) begin
      if (wr.add) used <= 1'b1;
      else if (wr.rm) used <= 1'b0;
    end
    if (wr.idx == my_idx) begin
      if (wr.add) begin
        peer <= wr.peer;
        ival <= wr.ival;
        due  <= wr.due;
      end
      if (wr.ival_en) ival <= wr.ival;
      if (wr.due_en) due <= wr.due;
    end
  end

  assign key = (clock_ms - due) ^ SIGN32;

  always_comb begin
    rec_next = rec_in;
    if (used && peer == id && !rec_in.hit) begin
      rec_next.hit     = 1'b1;
      rec_next.hit_idx = my_idx;
    end
    if (!used && !rec_in.free) begin
      rec_next.free     = 1'b1;
      rec_next.free_idx = my_idx;
    end
    if (used && (!rec_in.best || key > rec_in.best_key ||
                 (key == rec_in.best_key && peer < rec_in.best_peer))) begin
      rec_next.best      = 1'b1;
      rec_next.best_key  = key;
      rec_next.best_peer = peer;
      rec_next.best_ival = ival;
      rec_next.best_idx  = my_idx;
    end
  end

  // Hand the record to the next slot every cycle.
  always_ff @(posedge clk) begin
    if (rst) rec_out.vld <= 1'b0;
    else     rec_out.vld <= rec_next.vld;
    rec_out.hit       <= rec_next.hit;
    rec_out.hit_idx   <= rec_next.hit_idx;
    rec_out.free      <= rec_next.free;
    rec_out.free_idx  <= rec_next.free_idx;
    rec_out.best      <= rec_next.best;
    rec_out.best_key  <= rec_next.best_key;
    rec_out.best_peer <= rec_next.best_peer;
    rec_out.best_ival <= rec_next.best_ival;
    rec_out.best_idx  <= rec_next.best_idx;
  end

endmodule
`default_nettype wire

[verif/tb_periodic_peer_update_scheduler.sv]
// Testbench for the periodic peer update scheduler: directed and random requests checked live.
`default_nettype none

class due_scoreboard;
  bit          used [pps_pkg::MAX_PEERS];
  logic [15:0] peer [pps_pkg::MAX_PEERS];
  logic [15:0] ival [pps_pkg::MAX_PEERS];
  logic [31:0] due  [pps_pkg::MAX_PEERS];
  logic [31:0] now_ms;
  logic [15:0] def_ival;
  logic [6:0]  burst;
  logic [15:0] idle_wait;
  pps_pkg::res_t pending[$];
  int errors;

  function void clear();
    foreach (used[i]) used[i] = 0;
    now_ms = 0; def_ival = 50; burst = 64; idle_wait = 1000;
    pending.delete(); errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] data);
    if (idx == pps_pkg::CFG_DEF_IVAL) def_ival = data;
    else if (idx == pps_pkg::CFG_BURST) burst = data[6:0];
    else if (idx == pps_pkg::CFG_IDLE) idle_wait = data;
  endfunction

  function int lookup(logic [15:0] id);
    for (int i = 0; i < pps_pkg::MAX_PEERS; i++)
      if (used[i] && peer[i] == id) return i;
    return -1;
  endfunction

  // Pick the slot overdue longest; ties go to the lower peer id.
  function int most_late();
    int best;
    logic [31:0] key, best_key;
    best = -1; best_key = 0;
    for (int i = 0; i < pps_pkg::MAX_PEERS; i++) begin
      if (!used[i]) continue;
      key = (now_ms - due[i]) ^ pps_pkg::SIGN32;
      if (best < 0 || key > best_key || (key == best_key && peer[i] < peer[best])) begin
        best = i; best_key = key;
      end
    end
    return best;
  endfunction

  function logic [15:0] wait_left();
    int e;
    logic [31:0] rem;
    e = most_late();
    if (e < 0) return idle_wait;
    if (((now_ms - due[e]) & pps_pkg::SIGN32) == 0) return 0;
    rem = due[e] - now_ms;
    return rem > 32'hFFFF ? 16'hFFFF : rem[15:0];
  endfunction

  function void push(logic v, logic [15:0] p, logic l, logic [15:0] w, logic [2:0] s);
    pps_pkg::res_t r;
    r.peer_valid = v; r.due_peer = p; r.last = l; r.wait_ms = w; r.status = s;
    pending.insert(pending.size(), r);
  endfunction

  function void note_request(pps_pkg::req_t q);
    int s, n, lim, e;
    logic [2:0] st;
    st = pps_pkg::ST_OK;
    case (pps_pkg::req_code_t'(q.req_type))
      pps_pkg::REQ_ADD: begin
        if (lookup(q.peer_id) >= 0) st = pps_pkg::ST_DUP;
        else begin
          s = -1;
          for (int i = 0; i < pps_pkg::MAX_PEERS; i++)
            if (!used[i] && s < 0) s = i;
          if (s < 0) st = pps_pkg::ST_FULL;
          else begin
            used[s] = 1; peer[s] = q.peer_id; ival[s] = def_ival; due[s] = now_ms;
          end
        end
      end
      pps_pkg::REQ_RM: begin
        s = lookup(q.peer_id);
        if (s < 0) st = pps_pkg::ST_NOTFOUND; else used[s] = 0;
      end
      pps_pkg::REQ_IVAL: begin
        s = lookup(q.peer_id);
        if (s < 0) st = pps_pkg::ST_NOTFOUND; else ival[s] = q.ival_ms;
      end
      default: begin
        now_ms = now_ms + q.elapsed_ms;
        if (most_late() < 0) begin
          push(0, 0, 1, idle_wait, pps_pkg::ST_NOPEERS);
          return;
        end
        lim = burst;
        if (lim < 1) lim = 1;
        if (lim > pps_pkg::MAX_BURST) lim = pps_pkg::MAX_BURST;
        n = 0;
        while (n < lim) begin
          e = most_late();
          if (((now_ms - due[e]) & pps_pkg::SIGN32) != 0) break;
          due[e] = now_ms + ival[e];
          push(1, peer[e], 0, 0, pps_pkg::ST_OK);
          n++;
        end
        if (n == 0) push(0, 0, 1, wait_left(), pps_pkg::ST_OK);
        else begin
          pending[pending.size()-1].last = 1;
          pending[pending.size()-1].wait_ms = wait_left();
        end
        return;
      end
    endcase
    push(0, 0, 1, wait_left(), st);
  endfunction

  function void check_result(pps_pkg::res_t got);
    pps_pkg::res_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
      errors++;
    end
  endfunction
endclass

module tb_periodic_peer_update_scheduler;
  import pps_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  res_t        res;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  due_scoreboard sb = new();
  int gap_left = 0, burst_left = 0;
  logic [15:0] id_pool [8];

  periodic_peer_update_scheduler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Check every result word on the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res);
  end

  // Write one register; call only while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Hold one request word until the block takes it; idle in random bursts.
  // Start stays high after a word is taken, so the next word may follow at once.
  task automatic send_req(req_t q);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
    end
    if (gap_left > 0) begin
      start <= 0;
      repeat (gap_left) @(posedge clk);
    end
    gap_left = 0;
    burst_left--;
    start <= 1; req <= q;
    do @(posedge clk); while (busy);
    sb.note_request(q);
  endtask

  task automatic send(req_code_t t, logic [15:0] id, logic [15:0] iv, logic [15:0] el);
    req_t q;
    q.req_type = t; q.peer_id = id; q.ival_ms = iv; q.elapsed_ms = el;
    send_req(q);
  endtask

  // Drop start, drain all expected words, then let the block settle before a write.
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4 * (MAX_PEERS + 1)) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    req_t q;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      q = req_t'($bits(req_t)'({$urandom, $urandom}));
      // Mostly use a small pool of ids so removes and retimes find peers.
      if (k < 85) q.peer_id = id_pool[$urandom_range(0, 7)];
      if (k < 30) q.req_type = REQ_TICK;
      else if (k < 55) q.req_type = REQ_ADD;
      if (q.req_type == REQ_TICK && $urandom_range(0, 3) != 0)
        q.elapsed_ms = 16'($urandom_range(0, 120));
      if (q.req_type == REQ_IVAL && $urandom_range(0, 3) != 0)
        q.ival_ms = 16'($urandom_range(0, 100));
      send_req(q);
    end
  endtask

  initial begin
    sb.clear();
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000; id_pool[1] = 16'hFFFF;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty tick, add, duplicate, unknown peer, ties, zero interval.
    send(REQ_TICK, 0, 0, 16'hFFFF);
    send(REQ_RM, 16'h1234, 0, 0);
    send(REQ_IVAL, 16'h1234, 7, 0);
    send(REQ_ADD, 16'hFFFF, 0, 0);
    send(REQ_ADD, 16'h0000, 0, 0);
    send(REQ_ADD, 16'h0000, 0, 0);
    send(REQ_TICK, 0, 0, 0);
    send(REQ_TICK, 0, 0, 10);
    send(REQ_IVAL, 16'h0000, 16'hFFFF, 0);
    send(REQ_IVAL, 16'hFFFF, 0, 0);
    send(REQ_TICK, 0, 0, 60);
    send(REQ_RM, 16'hFFFF, 0, 0);
    send(REQ_TICK, 0, 0, 16'hFFFF);
    drain();
    write_reg(CFG_BURST, 16'd0);
    write_reg(CFG_DEF_IVAL, 16'd0);
    write_reg(CFG_IDLE, 16'hFFFF);
    for (int i = 1; i <= 17; i++) send(REQ_ADD, 16'(i * 977), 0, 0);
    send(REQ_TICK, 0, 0, 1);
    drain();
    write_reg(CFG_BURST, 16'd64);
    send(REQ_TICK, 0, 0, 0);
    for (int i = 1; i <= 16; i++) send(REQ_RM, 16'(i * 977), 0, 0);
    send(REQ_RM, 16'h0000, 0, 0);
    send(REQ_TICK, 0, 0, 5);
    drain();

    // Random phases, each under its own register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_DEF_IVAL, (ph == 0) ? 16'hFFFF : 16'($urandom_range(0, 80)));
      write_reg(CFG_BURST, (ph == 1) ? 16'd1 : (ph == 2) ? 16'd127 :
                16'($urandom_range(0, 64)));
      write_reg(CFG_IDLE, (ph == 3) ? 16'd0 : 16'($urandom));
      random_phase(43);
      drain();
    end

    if (sb.errors == 0)
      $display("periodic_peer_update_scheduler verification clean");
    else
      $display("periodic_peer_update_scheduler verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("periodic_peer_update_scheduler verification failed");
    $finish;
  end
endmodule
`default_nettype wire
